// ===== rtl/teq_pkg.sv =====
// Package for the timer expiry queue: field widths, codes, sequencer states, result word.
`default_nettype none

package teq_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 32;
  localparam int TIME_BITS_DEFAULT   = 48;
  localparam int MAX_RESULTS         = 32;

  localparam int ACT_W    = 2;
  localparam int TIME_W   = 48;
  localparam int ID_W     = 32;
  localparam int IVL_W    = 32;
  localparam int STATUS_W = 3;

  localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CANCEL = 2'd1;

  localparam logic [STATUS_W-1:0] STAT_ADDED     = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_CANCELLED = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_EXPIRED   = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_NONE      = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_SCAN,
    ST_ADD_END,
    ST_CAN_SCAN,
    ST_CAN_END,
    ST_MARK_SCAN,
    ST_SEL_SCAN,
    ST_SEL_END,
    ST_MIN_SCAN,
    ST_MIN_END,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     id;
    logic [TIME_W-1:0]   expiry;
    logic                repeats;
    logic                earliest;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/teq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module teq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/timer_expiry_queue.sv =====
// Timer expiry queue: timer table with add, cancel and tick under a scanning sequencer.
`default_nettype none

// A command is taken when start is high and busy is low; busy then stays high until the
// last result strobes. Every command walks the timer table one entry per cycle through
// the table RAM read port, with one shared compare unit. Add and cancel take one scan,
// a closing state and the emit state, and their single result strobes in the same cycle
// as busy drops. A tick with k due timers (k capped at 32) does a marking scan, one
// selection scan plus a closing state per due timer (and one more that finds none when k
// is under the cap), and a final scan for the next pending expiry, then its max(k, 1)
// results strobe one per cycle. Results are buffered and carry the next pending expiry as
// it stands after the whole command. The receiver cannot stall: each result is valid on
// its result_valid cycle only.

module timer_expiry_queue #(
  parameter int TABLE_DEPTH = teq_pkg::TABLE_DEPTH_DEFAULT,
  parameter int TIME_BITS   = teq_pkg::TIME_BITS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [teq_pkg::ACT_W-1:0]     action,
  input  wire logic [teq_pkg::TIME_W-1:0]    due_time,
  input  wire logic [teq_pkg::IVL_W-1:0]     repeat_interval,
  input  wire logic [teq_pkg::ID_W-1:0]      cancel_id,
  input  wire logic [teq_pkg::TIME_W-1:0]    current_time,
  output logic                               result_valid,
  output logic      [teq_pkg::STATUS_W-1:0]  status,
  output logic      [teq_pkg::ID_W-1:0]      timer_id,
  output logic      [teq_pkg::TIME_W-1:0]    expiry_time,
  output logic                               repeats,
  output logic                               earliest_changed,
  output logic                               next_valid,
  output logic      [teq_pkg::TIME_W-1:0]    next_expiry,
  output logic                               last
);

  import teq_pkg::*;

  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int ENT_W   = TIME_BITS + IVL_W + ID_W;
  localparam int BUF_AW  = $clog2(MAX_RESULTS);
  localparam int NRES_W  = $clog2(MAX_RESULTS + 1);
  localparam int SUM_W   = (TIME_BITS > IVL_W ? TIME_BITS : IVL_W) + 1;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  state_t state, state_next;

  // scan pipeline
  logic [CNT_W-1:0] cnt;
  logic             pv;
  logic [IDX_W-1:0] pidx;
  logic             in_scan, scan_first, scan_done;

  // captured command
  logic [TIME_BITS-1:0] due_r, now_r;
  logic [IVL_W-1:0]     ivl_r;
  logic [ID_W-1:0]      cid_r;

  // table state
  logic [TABLE_DEPTH-1:0] used;
  logic [TABLE_DEPTH-1:0] due_bits;
  logic [ID_W-1:0]        id_counter;

  // scan accumulators
  logic                 min_any;
  logic [TIME_BITS-1:0] min_exp;
  logic                 best_valid;
  logic [TIME_BITS-1:0] best_exp;
  logic [ID_W-1:0]      best_id;
  logic [IVL_W-1:0]     best_ivl;
  logic [IDX_W-1:0]     best_idx;
  logic                 free_found;
  logic [IDX_W-1:0]     free_idx;
  logic                 match_found;
  logic [IDX_W-1:0]     match_idx;

  // result buffer and emit
  logic [NRES_W-1:0]    n_res;
  logic [BUF_AW-1:0]    emit_idx;
  logic                 emit_final;
  logic                 nv_r;
  logic [TIME_BITS-1:0] ne_r;

  // table RAM
  logic             tbl_we;
  logic [IDX_W-1:0] tbl_waddr;
  logic [ENT_W-1:0] tbl_wdata;
  logic [ENT_W-1:0] tbl_rdata;
  logic [TIME_BITS-1:0] r_exp;
  logic [IVL_W-1:0]     r_ivl;
  logic [ID_W-1:0]      r_id;

  // buffer RAM
  logic              buf_we;
  logic [BUF_AW-1:0] buf_waddr;
  res_t              buf_wdata;
  res_t              buf_rdata;

  // shared compare unit and re-arm adder
  logic [TIME_BITS-1:0] cmp_a, cmp_b;
  logic                 exp_lt, exp_eq;
  logic                 add_ec;
  logic [SUM_W-1:0]     rearm_sum;
  logic [TIME_BITS-1:0] rearm_exp;

  assign r_exp = tbl_rdata[TIME_BITS-1:0];
  assign r_ivl = tbl_rdata[TIME_BITS +: IVL_W];
  assign r_id  = tbl_rdata[TIME_BITS + IVL_W +: ID_W];

  assign in_scan    = state inside {ST_ADD_SCAN, ST_CAN_SCAN, ST_MARK_SCAN, ST_SEL_SCAN,
                                    ST_MIN_SCAN};
  assign scan_first = in_scan && (cnt == '0);
  assign scan_done  = in_scan && pv && (pidx == IDX_W'(TABLE_DEPTH - 1));
  assign emit_final = (NRES_W'(emit_idx) + NRES_W'(1)) == n_res;

  always_comb begin
    cmp_a = (state == ST_ADD_END) ? due_r : r_exp;
    case (state)
      ST_MARK_SCAN: cmp_b = now_r;
      ST_SEL_SCAN:  cmp_b = best_exp;
      default:      cmp_b = min_exp;
    endcase
  end

  assign exp_lt = cmp_a < cmp_b;
  assign exp_eq = cmp_a == cmp_b;
  assign add_ec = !min_any || exp_lt;

  assign rearm_sum = SUM_W'(now_r) + SUM_W'(best_ivl);
  assign rearm_exp = (rearm_sum > SUM_W'(TIME_MAX)) ? TIME_MAX : rearm_sum[TIME_BITS-1:0];

  teq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (cnt[IDX_W-1:0]),
    .rdata (tbl_rdata)
  );

  teq_ram #(
    .WIDTH ($bits(res_t)),
    .DEPTH (MAX_RESULTS)
  ) u_results (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (buf_wdata),
    .raddr (emit_idx),
    .rdata (buf_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (action)
            ACT_ADD:    state_next = ST_ADD_SCAN;
            ACT_CANCEL: state_next = ST_CAN_SCAN;
            default:    state_next = ST_MARK_SCAN;
          endcase
        end
      end
      ST_ADD_SCAN:  if (scan_done) state_next = ST_ADD_END;
      ST_ADD_END:   state_next = ST_EMIT;
      ST_CAN_SCAN:  if (scan_done) state_next = ST_CAN_END;
      ST_CAN_END:   state_next = ST_EMIT;
      ST_MARK_SCAN: if (scan_done) state_next = ST_SEL_SCAN;
      ST_SEL_SCAN:  if (scan_done) state_next = ST_SEL_END;
      ST_SEL_END: begin
        if (!best_valid || n_res == NRES_W'(MAX_RESULTS - 1)) begin
          state_next = ST_MIN_SCAN;
        end else begin
          state_next = ST_SEL_SCAN;
        end
      end
      ST_MIN_SCAN:  if (scan_done) state_next = ST_MIN_END;
      ST_MIN_END:   state_next = ST_EMIT;
      ST_EMIT:      if (emit_final) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs: RAM writes and busy
  always_comb begin
    busy      = state != ST_IDLE;
    tbl_we    = 1'b0;
    tbl_waddr = free_idx;
    tbl_wdata = {id_counter, ivl_r, due_r};
    buf_we    = 1'b0;
    buf_waddr = '0;
    buf_wdata = '{status: STAT_NONE, id: '0, expiry: '0, repeats: 1'b0, earliest: 1'b0};
    case (state)
      ST_ADD_END: begin
        buf_we = 1'b1;
        if (free_found) begin
          tbl_we    = 1'b1;
          buf_wdata = '{status: STAT_ADDED, id: id_counter, expiry: '0, repeats: 1'b0,
                        earliest: add_ec};
        end else begin
          buf_wdata.status = STAT_FULL;
        end
      end
      ST_CAN_END: begin
        buf_we           = 1'b1;
        buf_wdata.status = match_found ? STAT_CANCELLED : STAT_NOT_FOUND;
        buf_wdata.id     = cid_r;
      end
      ST_SEL_END: begin
        if (best_valid) begin
          buf_we    = 1'b1;
          buf_waddr = n_res[BUF_AW-1:0];
          buf_wdata = '{status: STAT_EXPIRED, id: best_id, expiry: TIME_W'(best_exp),
                        repeats: best_ivl != '0, earliest: 1'b0};
          tbl_we    = best_ivl != '0;
          tbl_waddr = best_idx;
          tbl_wdata = {best_id, best_ivl, rearm_exp};
        end
      end
      ST_MIN_END: begin
        buf_we = n_res == '0;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      pv           <= 1'b0;
      used         <= '0;
      id_counter   <= ID_W'(1);
      n_res        <= '0;
      emit_idx     <= '0;
      result_valid <= 1'b0;
      last         <= 1'b0;
    end else begin
      state        <= state_next;
      pv           <= in_scan && !scan_done && (cnt < CNT_W'(TABLE_DEPTH));
      result_valid <= state == ST_EMIT;
      last         <= (state == ST_EMIT) && emit_final;
      if (in_scan) begin
        if (scan_done) begin
          cnt <= '0;
        end else if (cnt < CNT_W'(TABLE_DEPTH)) begin
          cnt <= cnt + CNT_W'(1);
        end
      end
      case (state)
        ST_IDLE: begin
          n_res <= '0;
        end
        ST_ADD_END: begin
          n_res    <= NRES_W'(1);
          emit_idx <= '0;
          if (free_found) begin
            used[free_idx] <= 1'b1;
            id_counter     <= id_counter + ID_W'(1);
          end
        end
        ST_CAN_END: begin
          n_res    <= NRES_W'(1);
          emit_idx <= '0;
          if (match_found) begin
            used[match_idx] <= 1'b0;
          end
        end
        ST_SEL_END: begin
          if (best_valid) begin
            n_res <= n_res + NRES_W'(1);
            if (best_ivl == '0) begin
              used[best_idx] <= 1'b0;
            end
          end
        end
        ST_MIN_END: begin
          emit_idx <= '0;
          if (n_res == '0) begin
            n_res <= NRES_W'(1);
          end
        end
        ST_EMIT: begin
          emit_idx <= emit_idx + BUF_AW'(1);
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    pidx <= cnt[IDX_W-1:0];
    if (state == ST_IDLE && start) begin
      due_r <= TIME_BITS'(due_time);
      now_r <= TIME_BITS'(current_time);
      ivl_r <= repeat_interval;
      cid_r <= cancel_id;
    end
    if (scan_first) begin
      min_any     <= 1'b0;
      best_valid  <= 1'b0;
      free_found  <= 1'b0;
      match_found <= 1'b0;
    end else if (pv) begin
      case (state)
        ST_ADD_SCAN: begin
          if (!used[pidx] && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= pidx;
          end
          if (used[pidx] && (!min_any || exp_lt)) begin
            min_any <= 1'b1;
            min_exp <= r_exp;
          end
        end
        ST_CAN_SCAN: begin
          // the first match is removed, so it stays out of the remaining minimum
          if (used[pidx] && r_id == cid_r && !match_found) begin
            match_found <= 1'b1;
            match_idx   <= pidx;
          end else if (used[pidx] && (!min_any || exp_lt)) begin
            min_any <= 1'b1;
            min_exp <= r_exp;
          end
        end
        ST_MARK_SCAN: begin
          due_bits[pidx] <= used[pidx] && (exp_lt || exp_eq);
        end
        ST_SEL_SCAN: begin
          // strict compare keeps the lowest index on full ties
          if (due_bits[pidx] &&
              (!best_valid || exp_lt || (exp_eq && r_id < best_id))) begin
            best_valid <= 1'b1;
            best_exp   <= r_exp;
            best_id    <= r_id;
            best_ivl   <= r_ivl;
            best_idx   <= pidx;
          end
        end
        ST_MIN_SCAN: begin
          if (used[pidx] && (!min_any || exp_lt)) begin
            min_any <= 1'b1;
            min_exp <= r_exp;
          end
        end
        default: ;
      endcase
    end
    case (state)
      ST_ADD_END: begin
        if (free_found) begin
          nv_r <= 1'b1;
          ne_r <= add_ec ? due_r : min_exp;
        end else begin
          nv_r <= min_any;
          ne_r <= min_any ? min_exp : '0;
        end
      end
      ST_CAN_END, ST_MIN_END: begin
        nv_r <= min_any;
        ne_r <= min_any ? min_exp : '0;
      end
      ST_SEL_END: begin
        if (best_valid) begin
          due_bits[best_idx] <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign status           = buf_rdata.status;
  assign timer_id         = buf_rdata.id;
  assign expiry_time      = buf_rdata.expiry;
  assign repeats          = buf_rdata.repeats;
  assign earliest_changed = buf_rdata.earliest;
  assign next_valid       = nv_r;
  assign next_expiry      = TIME_W'(ne_r);

endmodule

`default_nettype wire

// ===== bench/timer_expiry_queue_tb.sv =====
// Self-checking testbench for timer_expiry_queue: directed table, then shaped random traffic.
module timer_expiry_queue_tb;
  import teq_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEFAULT;
  localparam logic [ACT_W-1:0] ACT_TICK     = 2'd2;
  localparam logic [ACT_W-1:0] ACT_TICK_ALT = 2'd3;  // spare code, behaves as tick
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [IVL_W-1:0]  IVL_MAX  = '1;
  localparam int RANDOM_ITEMS = 430;
  localparam int CALM_TAIL    = 60;
  localparam int FILL_FIRST   = 150;
  localparam int FILL_LAST    = 185;
  localparam longint CYCLE_LIMIT = 3_000_000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     id;
    logic [TIME_W-1:0]   expiry;
    logic                repeats;
    logic                earliest;
    logic                nvalid;
    logic [TIME_W-1:0]   nexp;
    logic                fin;
  } report_t;

  typedef struct packed {
    logic [ACT_W-1:0]    act;
    logic [TIME_W-1:0]   due;
    logic [IVL_W-1:0]    ivl;
    logic [ID_W-1:0]     cid;
    logic [TIME_W-1:0]   now;
    logic                typed;
    logic [STATUS_W-1:0] t_status;
    logic [ID_W-1:0]     t_id;
  } plan_row_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [ACT_W-1:0]    action;
  logic [TIME_W-1:0]   due_time;
  logic [IVL_W-1:0]    repeat_interval;
  logic [ID_W-1:0]     cancel_id;
  logic [TIME_W-1:0]   current_time;
  logic                result_valid;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     timer_id;
  logic [TIME_W-1:0]   expiry_time;
  logic                repeats;
  logic                earliest_changed;
  logic                next_valid;
  logic [TIME_W-1:0]   next_expiry;
  logic                last;

  // shadow timer table
  bit                slot_used   [DEPTH];
  logic [TIME_W-1:0] slot_expiry [DEPTH];
  logic [IVL_W-1:0]  slot_ivl    [DEPTH];
  logic [ID_W-1:0]   slot_id     [DEPTH];
  logic [ID_W-1:0]   next_ident;

  report_t owed_reports[$];
  int      fault_count = 0;
  longint  cycle_count = 0;

  timer_expiry_queue DUT (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit soonest_expiry(output logic [TIME_W-1:0] t);
    bit any;
    logic [TIME_W-1:0] best;
    any = 1'b0;
    best = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (slot_used[i] && (!any || slot_expiry[i] < best)) begin
        best = slot_expiry[i];
        any = 1'b1;
      end
    end
    t = best;
    return any;
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[TIME_W-1:0];
  endfunction

  function automatic plan_row_t row(input logic [ACT_W-1:0] a, input logic [TIME_W-1:0] d,
                                    input logic [IVL_W-1:0] v, input logic [ID_W-1:0] c,
                                    input logic [TIME_W-1:0] n, input logic ty,
                                    input logic [STATUS_W-1:0] ts, input logic [ID_W-1:0] ti);
    plan_row_t r;
    r.act = a;
    r.due = d;
    r.ivl = v;
    r.cid = c;
    r.now = n;
    r.typed = ty;
    r.t_status = ts;
    r.t_id = ti;
    return r;
  endfunction

  // Applies one command to the shadow table and queues the reports it owes.
  task automatic apply_timer_cmd(input plan_row_t cmd, output report_t head);
    report_t batch[$];
    report_t r;
    bit due_now [DEPTH];
    logic [TIME_W-1:0] soonest;
    logic [TIME_W-1:0] nt;
    logic [TIME_W:0] rearm;
    bit any;
    bit nv;
    int slot;
    int pick;
    r = '0;
    if (cmd.act == ACT_ADD) begin
      slot = -1;
      for (int i = 0; i < DEPTH; i++)
        if (slot < 0 && !slot_used[i]) slot = i;
      if (slot < 0) begin
        r.status = STAT_FULL;
      end else begin
        any = soonest_expiry(soonest);
        r.status = STAT_ADDED;
        r.id = next_ident;
        r.earliest = !any || cmd.due < soonest;
        slot_used[slot] = 1'b1;
        slot_expiry[slot] = cmd.due;
        slot_ivl[slot] = cmd.ivl;
        slot_id[slot] = next_ident;
        next_ident = next_ident + 1'b1;
      end
      batch.push_back(r);
    end else if (cmd.act == ACT_CANCEL) begin
      slot = -1;
      for (int i = 0; i < DEPTH; i++)
        if (slot < 0 && slot_used[i] && slot_id[i] == cmd.cid) slot = i;
      if (slot >= 0) slot_used[slot] = 1'b0;
      r.status = (slot >= 0) ? STAT_CANCELLED : STAT_NOT_FOUND;
      r.id = cmd.cid;
      batch.push_back(r);
    end else begin
      for (int i = 0; i < DEPTH; i++)
        due_now[i] = slot_used[i] && slot_expiry[i] <= cmd.now;
      while (batch.size() < MAX_RESULTS) begin
        // earliest expiry first, ties by id, then by slot index
        pick = -1;
        for (int i = 0; i < DEPTH; i++) begin
          if (due_now[i] && (pick < 0 || slot_expiry[i] < slot_expiry[pick] ||
              (slot_expiry[i] == slot_expiry[pick] && slot_id[i] < slot_id[pick])))
            pick = i;
        end
        if (pick < 0) break;
        due_now[pick] = 1'b0;
        r = '0;
        r.status = STAT_EXPIRED;
        r.id = slot_id[pick];
        r.expiry = slot_expiry[pick];
        r.repeats = slot_ivl[pick] != '0;
        if (r.repeats) begin
          rearm = {1'b0, cmd.now} + slot_ivl[pick];
          slot_expiry[pick] = rearm[TIME_W] ? TIME_MAX : rearm[TIME_W-1:0];
        end else begin
          slot_used[pick] = 1'b0;
        end
        batch.push_back(r);
      end
      if (batch.size() == 0) begin
        r = '0;
        r.status = STAT_NONE;
        batch.push_back(r);
      end
    end
    nv = soonest_expiry(nt);
    foreach (batch[k]) begin
      batch[k].nvalid = nv;
      batch[k].nexp = nt;
      batch[k].fin = (k == batch.size() - 1);
      owed_reports.push_back(batch[k]);
    end
    head = batch[0];
  endtask

  // Holds the command until the transfer happens, then predicts it.
  task automatic send_cmd(input plan_row_t cmd, output report_t head);
    action <= cmd.act;
    due_time <= cmd.due;
    repeat_interval <= cmd.ivl;
    cancel_id <= cmd.cid;
    current_time <= cmd.now;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_timer_cmd(cmd, head);
  endtask

  task automatic idle_for(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fault_count++;
    end
  endtask

  always @(posedge clk) begin
    report_t want;
    if (!rst && result_valid) begin
      if (owed_reports.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0d id %0h",
                 $time, status, timer_id);
        fault_count++;
      end else begin
        want = owed_reports.pop_front();
        check_field("status", want.status, status);
        check_field("timer_id", want.id, timer_id);
        check_field("expiry_time", want.expiry, expiry_time);
        check_field("repeats", want.repeats, repeats);
        check_field("earliest_changed", want.earliest, earliest_changed);
        check_field("next_valid", want.nvalid, next_valid);
        check_field("next_expiry", want.nexp, next_expiry);
        check_field("last", want.fin, last);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    plan_row_t plan[$];
    plan_row_t cmd;
    report_t head;
    logic [TIME_W-1:0] clock_now;
    logic [ID_W-1:0] live[$];
    int roll;

    rst <= 1'b1;
    start <= 1'b0;
    action <= ACT_ADD;
    due_time <= '0;
    repeat_interval <= '0;
    cancel_id <= '0;
    current_time <= '0;
    for (int i = 0; i < DEPTH; i++) begin
      slot_used[i] = 1'b0;
      slot_expiry[i] = '0;
      slot_ivl[i] = '0;
      slot_id[i] = '0;
    end
    next_ident = 1;
    clock_now = '0;

    plan.push_back(row(ACT_TICK, 0, 0, 0, 0, 1, STAT_NONE, 0));
    plan.push_back(row(ACT_CANCEL, 0, 0, 5, 0, 1, STAT_NOT_FOUND, 5));
    plan.push_back(row(ACT_CANCEL, 0, 0, 32'hFFFF_FFFF, 0, 1, STAT_NOT_FOUND, 32'hFFFF_FFFF));
    plan.push_back(row(ACT_ADD, TIME_MAX, 0, 0, 0, 1, STAT_ADDED, 1));
    plan.push_back(row(ACT_ADD, 0, IVL_MAX, 0, 0, 1, STAT_ADDED, 2));
    plan.push_back(row(ACT_ADD, 100, 1, 0, 0, 1, STAT_ADDED, 3));
    plan.push_back(row(ACT_ADD, 100, 0, 0, 0, 1, STAT_ADDED, 4));
    plan.push_back(row(ACT_ADD, 100, 0, 0, 0, 1, STAT_ADDED, 5));
    plan.push_back(row(ACT_CANCEL, 0, 0, 5, 0, 1, STAT_CANCELLED, 5));
    plan.push_back(row(ACT_CANCEL, 0, 0, 5, 0, 1, STAT_NOT_FOUND, 5));
    plan.push_back(row(ACT_TICK, 0, 0, 0, 99, 1, STAT_EXPIRED, 2));
    // equal expiry: ordered by id
    plan.push_back(row(ACT_TICK_ALT, 0, 0, 0, 100, 0, 0, 0));
    plan.push_back(row(ACT_TICK, 0, 0, 0, 100, 0, 0, 0));
    plan.push_back(row(ACT_ADD, TIME_MAX - 1, 5, 0, 0, 1, STAT_ADDED, 6));
    // re-arm past the top of the time range saturates
    plan.push_back(row(ACT_TICK, 0, 0, 0, TIME_MAX, 0, 0, 0));
    plan.push_back(row(ACT_TICK, 0, 0, 0, TIME_MAX, 0, 0, 0));
    plan.push_back(row(ACT_CANCEL, 0, 0, 1, 0, 0, 0, 0));
    plan.push_back(row(ACT_CANCEL, 0, 0, 6, 0, 0, 0, 0));
    plan.push_back(row(ACT_CANCEL, 0, 0, 3, 0, 0, 0, 0));
    plan.push_back(row(ACT_CANCEL, 0, 0, 2, 0, 0, 0, 0));
    plan.push_back(row(ACT_TICK, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(row(ACT_ADD, 48'h5555_5555_5555, 32'hAAAA_AAAA, 0, 0, 0, 0, 0));
    plan.push_back(row(ACT_ADD, 48'hAAAA_AAAA_AAAA, 32'h5555_5555, 0, 0, 0, 0, 0));
    plan.push_back(row(ACT_CANCEL, 0, 0, 32'h8000_0000, 0, 1, STAT_NOT_FOUND, 32'h8000_0000));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      send_cmd(plan[k], head);
      if (plan[k].typed && (head.status !== plan[k].t_status || head.id !== plan[k].t_id)) begin
        $display("%0t: row %0d expected status %0d id %0h, predicted status %0d id %0h",
                 $time, k, plan[k].t_status, plan[k].t_id, head.status, head.id);
        fault_count++;
      end
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 50) begin
        // hold off until the block has delivered everything owed
        start <= 1'b0;
        @(posedge clk);
        while (owed_reports.size() != 0) @(posedge clk);
      end else if (i < RANDOM_ITEMS - CALM_TAIL && !(i >= 250 && i < 300) &&
                   $urandom_range(0, 3) == 0) begin
        idle_for($urandom_range(1, 8));
      end

      // unused fields carry noise
      cmd = '0;
      cmd.due = rand_time();
      cmd.ivl = $urandom;
      cmd.cid = $urandom;
      cmd.now = rand_time();

      if (i >= FILL_FIRST && i < FILL_LAST) roll = 0;         // fill past capacity
      else if (i == FILL_LAST) roll = 99;                     // drain with a full tick
      else roll = $urandom_range(0, 98);

      if (roll < 40) begin
        cmd.act = ACT_ADD;
        roll = $urandom_range(0, 99);
        if (roll < 70) cmd.due = clock_now + $urandom_range(0, 200);
        else if (roll < 85) cmd.due = clock_now + $urandom_range(0, 5);
        else if (roll < 95) cmd.due = rand_time();
        else if (roll < 98) cmd.due = TIME_MAX;
        else cmd.due = '0;
        roll = $urandom_range(0, 99);
        if (roll < 50) cmd.ivl = '0;
        else if (roll < 80) cmd.ivl = $urandom_range(1, 100);
        else if (roll < 90) cmd.ivl = IVL_MAX;
      end else if (roll < 65) begin
        cmd.act = ACT_CANCEL;
        live.delete();
        for (int s = 0; s < DEPTH; s++)
          if (slot_used[s]) live.push_back(slot_id[s]);
        if (live.size() > 0 && $urandom_range(0, 4) != 0)
          cmd.cid = live[$urandom_range(0, live.size() - 1)];
      end else begin
        cmd.act = ($urandom_range(0, 9) == 0) ? ACT_TICK_ALT : ACT_TICK;
        roll = (i == FILL_LAST) ? 0 : $urandom_range(0, 99);
        if (roll < 5) begin
          cmd.now = TIME_MAX;
          clock_now = $urandom_range(0, 1000);
        end else if (roll < 10) begin
          clock_now = $urandom_range(0, 1000);
        end else begin
          if (roll < 13) clock_now = $urandom_range(0, 1000);
          else clock_now = clock_now + $urandom_range(0, 60);
          cmd.now = clock_now;
        end
      end
      send_cmd(cmd, head);
    end

    start <= 1'b0;
    @(posedge clk);
    while (owed_reports.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (fault_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/teq_pkg.sv
rtl/teq_ram.sv
rtl/timer_expiry_queue.sv
bench/timer_expiry_queue_tb.sv
